// File: hw/rtl/face_uv_to_sphere_macros.svh
// Assertion macros for the cube-face to sphere block.
// Used by face_uv_to_sphere; no other dependencies.
`ifndef FACE_UV_TO_SPHERE_MACROS_SVH
`define FACE_UV_TO_SPHERE_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define FUVS_ASSERT_IMPL(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Implication after a fixed number of cycles, disabled while reset is high.
`define FUVS_ASSERT_DELAY(name, clk, rst, ante, dly, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##dly (cons)) \
      else $error(msg);

`endif

// File: hw/rtl/fuvs_pkg.sv
// Shared types, constants and width functions for the cube-face to sphere block.
// No dependencies.
package fuvs_pkg;

   localparam int FRAC_BITS_DEFAULT = 14;
   localparam int COORD_W = 16;
   localparam int FACE_W = 3;
   localparam int OUT_W = 16;
   localparam int OUT_MAX = 32767;
   localparam int OUT_MIN_MAG = 32768;
   localparam int AXES = 3;
   localparam int AX_X = 0;
   localparam int AX_Y = 1;
   localparam int AX_Z = 2;

   localparam logic [FACE_W-1:0] FACE_POS_X = 3'd0;
   localparam logic [FACE_W-1:0] FACE_NEG_X = 3'd1;
   localparam logic [FACE_W-1:0] FACE_POS_Y = 3'd2;
   localparam logic [FACE_W-1:0] FACE_NEG_Y = 3'd3;
   localparam logic [FACE_W-1:0] FACE_POS_Z = 3'd4;
   localparam logic [FACE_W-1:0] FACE_NEG_Z = 3'd5;

   typedef struct packed {
      logic valid;
      logic face_valid;
   } fuvs_ctl_type;

   function automatic int max2(int a, int b);
      return (a > b) ? a : b;
   endfunction

   // Signed width of a cube axis: holds a negated coordinate and +-1.0.
   function automatic int axis_width(int frac);
      return max2(COORD_W + 1, frac + 2);
   endfunction

   // Width of a rounded square, either pinned (1.0) or from a coordinate.
   function automatic int square_width(int frac);
      return max2(frac + 1, 2 * COORD_W + 1 - frac);
   endfunction

   // Signed width of the root argument scaled by six.
   function automatic int arg_width(int frac);
      int sw;
      sw = square_width(frac);
      return max2(max2(2 * frac + 3, sw + frac + 3), 2 * sw + 1) + 3;
   endfunction

   // Width of the root; the clamped argument is one bit narrower than arg_width.
   function automatic int root_width(int frac);
      return (arg_width(frac) - 2) / 2;
   endfunction

endpackage

// File: hw/rtl/fuvs_root_pipe.sv
// Pipelined digit-by-digit square root for three lanes, one root bit per stage.
// Finds the largest r with 6*r*r <= arg, which is floor(sqrt(floor(arg/6))).
// Depends on fuvs_pkg.
module fuvs_root_pipe
   import fuvs_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
   input  logic                                               clock,
   input  logic                                               reset,
   input  fuvs_ctl_type                                       in_ctl,
   input  logic [AXES-1:0][arg_width(FRAC_BITS)-2:0]          in_arg,
   input  logic [AXES-1:0][axis_width(FRAC_BITS)-1:0]         in_axis,
   output fuvs_ctl_type                                       out_ctl,
   output logic [AXES-1:0][root_width(FRAC_BITS)-1:0]         out_root,
   output logic [AXES-1:0][axis_width(FRAC_BITS)-1:0]         out_axis
);

   localparam int UW = arg_width(FRAC_BITS) - 1;
   localparam int RW = root_width(FRAC_BITS);
   localparam int AW = axis_width(FRAC_BITS);
   localparam int DW = UW + 4;

   fuvs_ctl_type                      ctl_in   [RW];
   fuvs_ctl_type                      ctl_ff   [RW];
   logic [AXES-1:0][UW-1:0]           rem_src  [RW];
   logic [AXES-1:0][RW-1:0]           root_src [RW];
   logic [AXES-1:0][UW-1:0]           rem_in   [RW];
   logic [AXES-1:0][RW-1:0]           root_in  [RW];
   logic [AXES-1:0][UW-1:0]           rem_ff   [RW];
   logic [AXES-1:0][RW-1:0]           root_ff  [RW];
   logic [AXES-1:0][AW-1:0]           axis_in  [RW];
   logic [AXES-1:0][AW-1:0]           axis_ff  [RW];

   // Stage j decides root bit RW-1-j. The remainder holds arg - 6*r*r, and
   // setting bit k of r costs 12*r*2^k + 6*2^(2k).
   always_comb begin
      logic [DW-1:0] r_w;
      logic [DW-1:0] d_w;
      logic [DW-1:0] rem_w;
      logic          take_w;
      for (int j = 0; j < RW; j++) begin
         if (j == 0) begin
            ctl_in[j]   = in_ctl;
            rem_src[j]  = in_arg;
            root_src[j] = '0;
            axis_in[j]  = in_axis;
         end else begin
            ctl_in[j]   = ctl_ff[j-1];
            rem_src[j]  = rem_ff[j-1];
            root_src[j] = root_ff[j-1];
            axis_in[j]  = axis_ff[j-1];
         end
         for (int l = 0; l < AXES; l++) begin
            r_w    = DW'(root_src[j][l]);
            rem_w  = DW'(rem_src[j][l]);
            d_w    = (((r_w << 3) + (r_w << 2)) << (RW - 1 - j))
                     + (DW'(6) << (2 * (RW - 1 - j)));
            take_w = (rem_w >= d_w);
            rem_in[j][l]  = take_w ? (rem_src[j][l] - d_w[UW-1:0]) : rem_src[j][l];
            root_in[j][l] = root_src[j][l] | (RW'(take_w) << (RW - 1 - j));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < RW; j++) begin
            ctl_ff[j] <= '0;
         end
      end else begin
         ctl_ff <= ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      root_ff <= root_in;
      axis_ff <= axis_in;
   end

   assign out_ctl  = ctl_ff[RW-1];
   assign out_root = root_ff[RW-1];
   assign out_axis = axis_ff[RW-1];

endmodule

// File: hw/rtl/face_uv_to_sphere.sv
// Cube-face coordinates to a point on the unit sphere, fully pipelined.
// Depends on fuvs_pkg, fuvs_root_pipe and face_uv_to_sphere_macros.svh.
//
// Usage:
//   An item is taken at a rising edge where start is high and busy is low.
//   busy is high only while reset is high, so one item can enter every cycle.
//   Each item carries the face number and the face coordinates u, v in
//   signed fixed point with FRAC_BITS fraction bits (1.0 = 2^FRAC_BITS).
//   Its result appears on the rsp_ ports for exactly one cycle, marked by
//   rsp_strobe, in the order the items were taken. Face numbers 6 and 7 give
//   zero components with rsp_face_valid low.
//   The pipeline has five stages for the squares, products and root
//   argument, one stage per root bit in the square-root chain, then the
//   output multiply and the rounding.
//   Throughput is one item per cycle.
//   The receiver cannot hold results off, and none is needed: nothing in the
//   pipeline ever waits. A synchronous reset drops every item in flight;
//   the block takes items again in the cycle after reset falls.
`include "face_uv_to_sphere_macros.svh"

module face_uv_to_sphere
   import fuvs_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic signed [COORD_W-1:0]   req_coord_u,
   input  logic signed [COORD_W-1:0]   req_coord_v,
   input  logic        [FACE_W-1:0]    req_face_id,
   output logic                        rsp_strobe,
   output logic signed [OUT_W-1:0]     rsp_sphere_x,
   output logic signed [OUT_W-1:0]     rsp_sphere_y,
   output logic signed [OUT_W-1:0]     rsp_sphere_z,
   output logic                        rsp_face_valid
);

   localparam int AW = axis_width(FRAC_BITS);
   localparam int MW = AW - 1;
   localparam int SW = square_width(FRAC_BITS);
   localparam int NW = arg_width(FRAC_BITS);
   localparam int UW = NW - 1;
   localparam int RW = root_width(FRAC_BITS);
   localparam int PW = MW + RW;
   localparam int QW = PW + 1 - FRAC_BITS;
   localparam int PSQ = 2 * COORD_W;
   localparam int LATENCY = RW + 7;
   localparam logic [AW-1:0] ONE_A = AW'(1) << FRAC_BITS;
   localparam logic [SW-1:0] ONE_S = SW'(1) << FRAC_BITS;

   // Stage 1: captured item.
   fuvs_ctl_type                ctl1_in, ctl1_ff;
   logic [COORD_W-1:0]          u1_ff, v1_ff;
   logic [FACE_W-1:0]           face1_ff;
   // Stage 2: axes and raw coordinate squares.
   fuvs_ctl_type                ctl2_ff;
   logic [AXES-1:0][AW-1:0]     axis2_in, axis2_ff;
   logic [COORD_W-1:0]          mag_u, mag_v;
   logic [PSQ-1:0]              pu2_in, pv2_in, pu2_ff, pv2_ff;
   logic [FACE_W-1:0]           face2_ff;
   // Stage 3: rounded squares per axis.
   fuvs_ctl_type                ctl3_ff;
   logic [AXES-1:0][AW-1:0]     axis3_ff;
   logic [SW-1:0]               squ, sqv;
   logic [AXES-1:0][SW-1:0]     sq3_in, sq3_ff;
   // Stage 4: cross products of the squares.
   fuvs_ctl_type                ctl4_ff;
   logic [AXES-1:0][AW-1:0]     axis4_ff;
   logic [AXES-1:0][SW-1:0]     sq4_ff;
   logic [AXES-1:0][2*SW-1:0]   prod4_in, prod4_ff;
   // Stage 5: clamped root arguments.
   fuvs_ctl_type                ctl5_ff;
   logic [AXES-1:0][AW-1:0]     axis5_ff;
   logic [AXES-1:0][UW-1:0]     arg5_in, arg5_ff;
   // Root pipeline outputs.
   fuvs_ctl_type                root_ctl;
   logic [AXES-1:0][RW-1:0]     root_val;
   logic [AXES-1:0][AW-1:0]     root_axis;
   // Stage 6: scaled magnitudes.
   fuvs_ctl_type                ctl6_ff;
   logic [AXES-1:0][PW-1:0]     prod6_in, prod6_ff;
   logic [AXES-1:0]             neg6_in, neg6_ff;
   // Output stage.
   logic                        strobe_ff;
   logic                        fvalid_ff;
   logic [AXES-1:0][OUT_W-1:0]  res_in, res_ff;

   assign busy = reset;

   assign ctl1_in.valid      = start && !busy;
   assign ctl1_in.face_valid = (req_face_id <= FACE_NEG_Z);

   always_comb begin
      logic [AW-1:0] u_a;
      logic [AW-1:0] v_a;
      u_a = {{(AW - COORD_W){u1_ff[COORD_W-1]}}, u1_ff};
      v_a = {{(AW - COORD_W){v1_ff[COORD_W-1]}}, v1_ff};
      // The square of -u equals that of u, so squares come from |u| and |v|.
      mag_u  = u1_ff[COORD_W-1] ? (~u1_ff + COORD_W'(1)) : u1_ff;
      mag_v  = v1_ff[COORD_W-1] ? (~v1_ff + COORD_W'(1)) : v1_ff;
      pu2_in = PSQ'(mag_u) * PSQ'(mag_u);
      pv2_in = PSQ'(mag_v) * PSQ'(mag_v);
      unique case (face1_ff)
         FACE_POS_X: begin
            axis2_in[AX_X] = ONE_A;
            axis2_in[AX_Y] = v_a;
            axis2_in[AX_Z] = ~u_a + AW'(1);
         end
         FACE_NEG_X: begin
            axis2_in[AX_X] = ~ONE_A + AW'(1);
            axis2_in[AX_Y] = v_a;
            axis2_in[AX_Z] = u_a;
         end
         FACE_POS_Y: begin
            axis2_in[AX_X] = u_a;
            axis2_in[AX_Y] = ONE_A;
            axis2_in[AX_Z] = ~v_a + AW'(1);
         end
         FACE_NEG_Y: begin
            axis2_in[AX_X] = u_a;
            axis2_in[AX_Y] = ~ONE_A + AW'(1);
            axis2_in[AX_Z] = v_a;
         end
         FACE_POS_Z: begin
            axis2_in[AX_X] = u_a;
            axis2_in[AX_Y] = v_a;
            axis2_in[AX_Z] = ONE_A;
         end
         FACE_NEG_Z: begin
            axis2_in[AX_X] = ~u_a + AW'(1);
            axis2_in[AX_Y] = v_a;
            axis2_in[AX_Z] = ~ONE_A + AW'(1);
         end
         default: begin
            axis2_in = '0;
         end
      endcase
   end

   always_comb begin
      logic [PSQ:0] su_w;
      logic [PSQ:0] sv_w;
      su_w = (PSQ + 1)'(pu2_ff) + ((PSQ + 1)'(1) << (FRAC_BITS - 1));
      sv_w = (PSQ + 1)'(pv2_ff) + ((PSQ + 1)'(1) << (FRAC_BITS - 1));
      squ  = SW'(su_w >> FRAC_BITS);
      sqv  = SW'(sv_w >> FRAC_BITS);
      // The pinned axis has a square of exactly one.
      unique case (face2_ff) inside
         FACE_POS_X, FACE_NEG_X: begin
            sq3_in[AX_X] = ONE_S;
            sq3_in[AX_Y] = sqv;
            sq3_in[AX_Z] = squ;
         end
         FACE_POS_Y, FACE_NEG_Y: begin
            sq3_in[AX_X] = squ;
            sq3_in[AX_Y] = ONE_S;
            sq3_in[AX_Z] = sqv;
         end
         FACE_POS_Z, FACE_NEG_Z: begin
            sq3_in[AX_X] = squ;
            sq3_in[AX_Y] = sqv;
            sq3_in[AX_Z] = ONE_S;
         end
         default: begin
            sq3_in = '0;
         end
      endcase
   end

   // Each axis is scaled by a root over the other two axes' squares.
   always_comb begin
      logic [NW-1:0] s_w;
      logic [NW-1:0] n_w;
      int            b;
      int            c;
      for (int l = 0; l < AXES; l++) begin
         b = (l == AX_X) ? AX_Y : AX_X;
         c = (l == AX_Z) ? AX_Y : AX_Z;
         prod4_in[l] = (2 * SW)'(sq3_ff[b]) * (2 * SW)'(sq3_ff[c]);
         s_w = NW'(sq4_ff[b]) + NW'(sq4_ff[c]);
         n_w = (NW'(6) << (2 * FRAC_BITS)) - (((s_w << 1) + s_w) << FRAC_BITS)
               + (NW'(prod4_ff[l]) << 1);
         arg5_in[l] = n_w[NW-1] ? '0 : n_w[UW-1:0];
      end
   end

   fuvs_root_pipe #(
      .FRAC_BITS (FRAC_BITS)
   ) u_root (
      .clock    (clock),
      .reset    (reset),
      .in_ctl   (ctl5_ff),
      .in_arg   (arg5_ff),
      .in_axis  (axis5_ff),
      .out_ctl  (root_ctl),
      .out_root (root_val),
      .out_axis (root_axis)
   );

   always_comb begin
      logic [AW-1:0] m_w;
      for (int l = 0; l < AXES; l++) begin
         neg6_in[l]  = root_axis[l][AW-1];
         m_w         = neg6_in[l] ? (~root_axis[l] + AW'(1)) : root_axis[l];
         prod6_in[l] = PW'(m_w[MW-1:0]) * PW'(root_val[l]);
      end
   end

   // Round half away from zero on the magnitude, then saturate to 16 bits.
   always_comb begin
      logic [PW:0]   sum_w;
      logic [QW-1:0] q_w;
      for (int l = 0; l < AXES; l++) begin
         sum_w = (PW + 1)'(prod6_ff[l]) + ((PW + 1)'(1) << (FRAC_BITS - 1));
         q_w   = sum_w[PW:FRAC_BITS];
         if (!ctl6_ff.face_valid) begin
            res_in[l] = '0;
         end else if (neg6_ff[l]) begin
            res_in[l] = (q_w > QW'(OUT_MIN_MAG)) ? OUT_W'(OUT_MIN_MAG)
                                                  : (~q_w[OUT_W-1:0] + OUT_W'(1));
         end else begin
            res_in[l] = (q_w > QW'(OUT_MAX)) ? OUT_W'(OUT_MAX) : q_w[OUT_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl1_ff   <= '0;
         ctl2_ff   <= '0;
         ctl3_ff   <= '0;
         ctl4_ff   <= '0;
         ctl5_ff   <= '0;
         ctl6_ff   <= '0;
         strobe_ff <= 1'b0;
      end else begin
         ctl1_ff   <= ctl1_in;
         ctl2_ff   <= ctl1_ff;
         ctl3_ff   <= ctl2_ff;
         ctl4_ff   <= ctl3_ff;
         ctl5_ff   <= ctl4_ff;
         ctl6_ff   <= root_ctl;
         strobe_ff <= ctl6_ff.valid;
      end
   end

   always_ff @(posedge clock) begin
      u1_ff     <= req_coord_u;
      v1_ff     <= req_coord_v;
      face1_ff  <= req_face_id;
      axis2_ff  <= axis2_in;
      pu2_ff    <= pu2_in;
      pv2_ff    <= pv2_in;
      face2_ff  <= face1_ff;
      axis3_ff  <= axis2_ff;
      sq3_ff    <= sq3_in;
      axis4_ff  <= axis3_ff;
      sq4_ff    <= sq3_ff;
      prod4_ff  <= prod4_in;
      axis5_ff  <= axis4_ff;
      arg5_ff   <= arg5_in;
      prod6_ff  <= prod6_in;
      neg6_ff   <= neg6_in;
      res_ff    <= res_in;
      fvalid_ff <= ctl6_ff.face_valid;
   end

   assign rsp_strobe     = strobe_ff;
   assign rsp_sphere_x   = res_ff[AX_X];
   assign rsp_sphere_y   = res_ff[AX_Y];
   assign rsp_sphere_z   = res_ff[AX_Z];
   assign rsp_face_valid = fvalid_ff;

   `FUVS_ASSERT_DELAY(a_fixed_latency, clock, reset, start && !busy, LATENCY, rsp_strobe, "item taken but no result after the pipeline latency")
   `FUVS_ASSERT_IMPL(a_no_extra_result, clock, reset, rsp_strobe, $past(start && !busy, LATENCY), "result strobe without an item taken one latency earlier")
   `FUVS_ASSERT_IMPL(a_face_flag, clock, reset, rsp_strobe, rsp_face_valid == $past(req_face_id <= FACE_NEG_Z, LATENCY), "face valid flag does not match the face of its item")
   `FUVS_ASSERT_IMPL(a_invalid_zero, clock, reset, rsp_strobe && !rsp_face_valid, rsp_sphere_x == '0 && rsp_sphere_y == '0 && rsp_sphere_z == '0, "invalid face gave nonzero components")

endmodule
